// ===== hw/rtl/mlpq_pkg.sv =====
package mlpq_pkg;

   localparam int ID_W    = 32;
   localparam int TIME_W  = 32;
   localparam int DATA_W  = 32;
   localparam int PRIO_W  = 3;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_ADMIT = 2'd1,
      CMD_POP   = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] start_time;
      logic [DATA_W-1:0] payload;
   } record_type;

   localparam int REC_W = $bits(record_type);

endpackage

// ===== hw/rtl/mlpq_if.sv =====
interface mlpq_req_if
   import mlpq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [PRIO_W-1:0] priority_req;
   logic [ID_W-1:0]   proc_id;
   logic [TIME_W-1:0] start_time;
   logic [TIME_W-1:0] clock_now;
   logic [DATA_W-1:0] payload;

   modport source (
      output valid, cmd, priority_req, proc_id, start_time, clock_now, payload,
      input  ready
   );
   modport sink (
      input  valid, cmd, priority_req, proc_id, start_time, clock_now, payload,
      output ready
   );
endinterface

interface mlpq_rsp_if
   import mlpq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PRIO_W-1:0] out_priority;
   logic [ID_W-1:0]   out_id;
   logic [TIME_W-1:0] out_start_time;
   logic [DATA_W-1:0] out_payload;
   logic              all_empty;

   modport source (
      output valid, status, out_priority, out_id, out_start_time, out_payload, all_empty,
      input  ready
   );
   modport sink (
      input  valid, status, out_priority, out_id, out_start_time, out_payload, all_empty,
      output ready
   );
endinterface

// ===== hw/rtl/mlpq_ram.sv =====
module mlpq_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/multilevel_priority_queue.sv =====
// Multi-level priority queue: NUM_LEVELS FIFOs of LEVEL_DEPTH records each, a record being
// id, start time and payload. Push (cmd 0) stores the record as given, admit (cmd 1) stores it
// with the next id of a wrapping counter and clock_now as start time, pop (cmd 2) takes the
// oldest record of the highest non-empty level. Every request yields exactly one response,
// via the input and result registers. One request is taken per cycle unless the response
// side stalls: the records sit in a single RAM with one write and one registered read port,
// and each command uses at most one of the two, while the per-level pointers and counts sit
// in flip-flops and a priority encoder over the non-empty flags picks the level to pop. A
// full level, a level of NUM_LEVELS or more or a pop on an empty queue is reported in status
// and leaves the queue unchanged. The record RAM needs no clearing after reset.
module multilevel_priority_queue
   import mlpq_pkg::*;
#(
   parameter int NUM_LEVELS  = 8,
   parameter int LEVEL_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   mlpq_req_if.sink    req_chan,
   mlpq_rsp_if.source  rsp_chan
);

   localparam int SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int TOT_W  = $clog2(SLOTS + 1);
   localparam int ADDR_W = $clog2(SLOTS);

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [PRIO_W-1:0] s1_prio_ff;
   logic [ID_W-1:0]   s1_pid_ff;
   logic [TIME_W-1:0] s1_st_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic [DATA_W-1:0] s1_pl_ff;

   // queue state
   logic [PTR_W-1:0] head_ff [NUM_LEVELS];
   logic [PTR_W-1:0] head_in [NUM_LEVELS];
   logic [PTR_W-1:0] tail_ff [NUM_LEVELS];
   logic [PTR_W-1:0] tail_in [NUM_LEVELS];
   logic [CNT_W-1:0] count_ff [NUM_LEVELS];
   logic [CNT_W-1:0] count_in [NUM_LEVELS];
   logic [TOT_W-1:0] total_ff, total_in;
   logic [ID_W-1:0]  next_id_ff, next_id_in;

   // result register
   logic              s2_valid_ff, s2_valid_in;
   status_type        s2_status_ff, s2_status_in;
   logic [PRIO_W-1:0] s2_prio_ff, s2_prio_in;
   logic [ID_W-1:0]   s2_id_ff, s2_id_in;
   logic              s2_pop_ff, s2_pop_in;
   logic              s2_empty_ff, s2_empty_in;

   logic                  adv, req_xfer, fire;
   cmd_type               cmd;
   logic [LVL_W-1:0]      lvl, top;
   logic                  in_range, level_full, any_nonempty, is_push;
   logic [NUM_LEVELS-1:0] nonempty;
   logic                  do_push, do_pop;
   status_type            status;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   record_type            wr_rec, rd_rec;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign adv            = !s2_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || adv;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign fire           = s1_valid_ff && adv;
   assign s1_valid_in    = req_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);

   always_comb begin
      cmd      = cmd_type'(s1_cmd_ff);
      lvl      = LVL_W'(s1_prio_ff);
      in_range = int'(s1_prio_ff) < NUM_LEVELS;
      is_push  = (cmd == CMD_PUSH) || (cmd == CMD_ADMIT);
      for (int i = 0; i < NUM_LEVELS; i++) begin
         nonempty[i] = count_ff[i] != '0;
      end
      any_nonempty = |nonempty;
      // highest set flag wins
      top = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (nonempty[i]) begin
            top = LVL_W'(i);
         end
      end
      level_full = in_range && (count_ff[lvl] == CNT_W'(LEVEL_DEPTH));
   end

   always_comb begin
      status = STATUS_OK;
      case (cmd)
         CMD_PUSH, CMD_ADMIT: begin
            if (!in_range) begin
               status = STATUS_RANGE;
            end else if (level_full) begin
               status = STATUS_FULL;
            end
         end
         CMD_POP: begin
            if (!any_nonempty) begin
               status = STATUS_EMPTY;
            end
         end
         default: status = STATUS_OK;
      endcase
   end

   assign do_push = fire && is_push && (status == STATUS_OK);
   assign do_pop  = fire && (cmd == CMD_POP) && any_nonempty;

   assign wr_addr = ADDR_W'(int'(lvl) * LEVEL_DEPTH + int'(tail_ff[lvl]));
   assign rd_addr = ADDR_W'(int'(top) * LEVEL_DEPTH + int'(head_ff[top]));

   always_comb begin
      wr_rec.id         = (cmd == CMD_ADMIT) ? next_id_ff : s1_pid_ff;
      wr_rec.start_time = (cmd == CMD_ADMIT) ? s1_now_ff : s1_st_ff;
      wr_rec.payload    = s1_pl_ff;
   end

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      next_id_in = next_id_ff;
      if (do_push) begin
         tail_in[lvl]  = ptr_inc(tail_ff[lvl]);
         count_in[lvl] = count_ff[lvl] + 1'b1;
         total_in      = total_ff + 1'b1;
         if (cmd == CMD_ADMIT) begin
            next_id_in = next_id_ff + 1'b1;
         end
      end
      if (do_pop) begin
         head_in[top]  = ptr_inc(head_ff[top]);
         count_in[top] = count_ff[top] - 1'b1;
         total_in      = total_ff - 1'b1;
      end
   end

   always_comb begin
      s2_valid_in  = adv ? s1_valid_ff : s2_valid_ff;
      s2_status_in = status;
      s2_prio_in   = do_pop ? PRIO_W'(top) : '0;
      s2_id_in     = (do_push && cmd == CMD_ADMIT) ? next_id_ff : '0;
      s2_pop_in    = do_pop;
      s2_empty_in  = total_in == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         head_ff     <= '{default: '0};
         tail_ff     <= '{default: '0};
         count_ff    <= '{default: '0};
         total_ff    <= '0;
         next_id_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
         next_id_ff  <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_cmd_ff  <= req_chan.cmd;
         s1_prio_ff <= req_chan.priority_req;
         s1_pid_ff  <= req_chan.proc_id;
         s1_st_ff   <= req_chan.start_time;
         s1_now_ff  <= req_chan.clock_now;
         s1_pl_ff   <= req_chan.payload;
      end
      if (fire) begin
         s2_status_ff <= s2_status_in;
         s2_prio_ff   <= s2_prio_in;
         s2_id_ff     <= s2_id_in;
         s2_pop_ff    <= s2_pop_in;
         s2_empty_ff  <= s2_empty_in;
      end
   end

   mlpq_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (do_pop),
      .rd_addr (rd_addr),
      .rd_data (rd_rec)
   );

   assign rsp_chan.valid          = s2_valid_ff;
   assign rsp_chan.status         = s2_status_ff;
   assign rsp_chan.out_priority   = s2_prio_ff;
   assign rsp_chan.out_id         = s2_pop_ff ? rd_rec.id : s2_id_ff;
   assign rsp_chan.out_start_time = s2_pop_ff ? rd_rec.start_time : '0;
   assign rsp_chan.out_payload    = s2_pop_ff ? rd_rec.payload : '0;
   assign rsp_chan.all_empty      = s2_empty_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOT_W'(SLOTS))
      else $error("occupancy above capacity");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      do_push |=> total_ff == TOT_W'($past(total_ff) + 1'b1))
      else $error("accepted push did not raise occupancy");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == STATUS_EMPTY |-> rsp_chan.all_empty)
      else $error("empty pop reported non-empty queue");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != STATUS_OK |->
         rsp_chan.out_id == '0 && rsp_chan.out_start_time == '0 &&
         rsp_chan.out_payload == '0 && rsp_chan.out_priority == '0)
      else $error("failed command returned record fields");

endmodule
